// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register indexes, constants and the divider step function.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned DW       = 32;  // datapath word
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned TempW    = 12;
  localparam int unsigned PresW    = 17;
  localparam int unsigned UtW      = 16;
  localparam int unsigned UpW      = 24;
  localparam int unsigned DefSideW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAIR_A   = 3'd0,
    CFG_PAIR_B   = 3'd1,
    CFG_PAIR_C   = 3'd2,
    CFG_PAIR_D   = 3'd3,
    CFG_PAIR_E   = 3'd4,
    CFG_OVERSAMP = 3'd5
  } cfg_idx_e;

  localparam logic [DW-1:0] TempBias  = 32'd4000;
  localparam logic [DW-1:0] B4Bias    = 32'd32768;
  localparam logic [DW-1:0] PresScale = 32'd50000;
  localparam logic [DW-1:0] PolyA     = 32'd3038;
  localparam logic [DW-1:0] PolyB     = 32'd7357;
  localparam logic [DW-1:0] PolyC     = 32'd3791;
  localparam logic signed [DW-1:0] TempMin = -32'sd2048;
  localparam logic signed [DW-1:0] TempMax = 32'sd2047;
  localparam logic signed [DW-1:0] PresMax = 32'sd131071;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic logic [2*DW-1:0] div_step(input logic [DW-1:0] rem,
                                               input logic [DW-1:0] nq,
                                               input logic [DW-1:0] den);
    logic [DW:0] r;
    logic        qb;
    r  = {rem, nq[DW-1]};
    qb = 1'b0;
    if (r >= {1'b0, den}) begin
      r  = r - {1'b0, den};
      qb = 1'b1;
    end
    return {r[DW-1:0], nq[DW-2:0], qb};
  endfunction

endpackage

// ===== sv/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Unsigned 32-bit pipelined divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module bpc_div import bpc_pkg::*; #(
  parameter int unsigned SideW = DefSideW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DW-1:0]    quo_o,
  output logic [SideW-1:0] side_o
);

  logic [DW-1:0]    rem_q  [DW];
  logic [DW-1:0]    nq_q   [DW];
  logic [DW-1:0]    den_q  [DW];
  logic [SideW-1:0] side_q [DW];
  logic [DW-1:0]    v_q;

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0]    rem_in, nq_in, den_in;
    logic [SideW-1:0] side_in;
    logic             v_in;
    logic [2*DW-1:0]  step;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end
    assign step = div_step(rem_in, nq_in, den_in);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= step[2*DW-1:DW];
        nq_q[k]   <= step[DW-1:0];
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[DW-1];
  assign quo_o   = nq_q[DW-1];
  assign side_o  = side_q[DW-1];

endmodule

// ===== sv/barometer_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation
// Integer compensation of raw temperature and pressure sensor readings.
// ----------------------------------------------------------------------------
// A fully pipelined datapath: one sample pair enters per clock while the
// output is not stalled. The latency is set by the two 32-stage pipelined
// dividers (the temperature quotient and the pressure quotient) plus the
// multiply stages around them. All stages advance together; a stall on the
// output holds the whole pipe and drops s_axis_tready. Write calibration
// only while idle.
// A zero divisor on either path gives divide_fault (tuser) with zero data.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // [15:0] raw_temperature, [39:16] raw_pressure_bytes
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [11:0] temperature_tenths, [28:12] pressure_pascal
  output logic               m_axis_tuser,   // [0] divide_fault
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DW-1:0]      cfg_data_i
);

  // Calibration registers
  logic [DW-1:0] pair_a_q, pair_b_q, pair_c_q, pair_d_q, pair_e_q;
  logic [1:0]    oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_a_q <= '0;
      pair_b_q <= '0;
      pair_c_q <= '0;
      pair_d_q <= '0;
      pair_e_q <= '0;
      oss_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAIR_A:   pair_a_q <= cfg_data_i;
        CFG_PAIR_B:   pair_b_q <= cfg_data_i;
        CFG_PAIR_C:   pair_c_q <= cfg_data_i;
        CFG_PAIR_D:   pair_d_q <= cfg_data_i;
        CFG_PAIR_E:   pair_e_q <= cfg_data_i;
        CFG_OVERSAMP: oss_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Coefficients, sign- or zero-extended to the word
  logic [DW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{pair_a_q[31]}}, pair_a_q[31:16]};
  assign ac2 = {{16{pair_a_q[15]}}, pair_a_q[15:0]};
  assign ac3 = {{16{pair_b_q[31]}}, pair_b_q[31:16]};
  assign ac4 = {16'd0, pair_b_q[15:0]};
  assign ac5 = {16'd0, pair_c_q[31:16]};
  assign ac6 = {16'd0, pair_c_q[15:0]};
  assign b1  = {{16{pair_d_q[31]}}, pair_d_q[31:16]};
  assign b2  = {{16{pair_d_q[15]}}, pair_d_q[15:0]};
  assign mc  = {{16{pair_e_q[31]}}, pair_e_q[31:16]};
  assign md  = {{16{pair_e_q[15]}}, pair_e_q[15:0]};

  // Global advance: the whole pipe moves unless a finished beat is stalled
  logic adv;
  logic out_v_q;
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Stage A: align pressure readout, first temperature product
  logic [DW-1:0]  a_prod_q;
  logic [UpW-1:0] a_up_q;
  logic           a_v_q;
  logic [UtW-1:0] ut;
  logic [UpW-1:0] raw_up;
  assign ut     = s_axis_tdata[15:0];
  assign raw_up = s_axis_tdata[39:16];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_prod_q <= ({16'd0, ut} - ac6) * ac5;
      a_up_q   <= raw_up >> (4'd8 - {2'b00, oss_q});
    end
  end

  // Stage B: temperature divisor
  logic [DW-1:0]  b_x1_q, b_div_q;
  logic [UpW-1:0] b_up_q;
  logic           b_v_q;
  logic [DW-1:0]  x1_t;
  assign x1_t = $signed(a_prod_q) >>> 15;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_x1_q  <= x1_t;
      b_div_q <= x1_t + md;
      b_up_q  <= a_up_q;
    end
  end

  // Signed divide of MC<<11 by the divisor through magnitudes
  localparam int unsigned Side1W = DW + UpW + 2;
  logic [DW-1:0]     num1, num1_mag, den1_mag, quo1;
  logic              sign1, fault1;
  logic [Side1W-1:0] side1_out;
  logic              d1_v;
  assign num1     = mc << 11;
  assign num1_mag = num1[DW-1] ? (32'd0 - num1) : num1;
  assign den1_mag = b_div_q[DW-1] ? (32'd0 - b_div_q) : b_div_q;
  assign sign1    = num1[DW-1] ^ b_div_q[DW-1];
  assign fault1   = (b_div_q == '0);

  bpc_div #(.SideW(Side1W)) u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_v_q),
    .num_i   (num1_mag),
    .den_i   (den1_mag),
    .side_i  ({sign1, fault1, b_up_q, b_x1_q}),
    .valid_o (d1_v),
    .quo_o   (quo1),
    .side_o  (side1_out)
  );

  // Stage C: B5
  logic [DW-1:0]  c_b5_q;
  logic [UpW-1:0] c_up_q;
  logic           c_fault_q, c_v_q;
  logic [DW-1:0]  x2_t;
  assign x2_t = side1_out[Side1W-1] ? (32'd0 - quo1) : quo1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_b5_q    <= side1_out[DW-1:0] + x2_t;
      c_up_q    <= side1_out[DW+UpW-1:DW];
      c_fault_q <= side1_out[Side1W-2];
    end
  end

  // Stage D: temperature result, B6 and its square
  logic [DW-1:0]    d_b6_q, d_sq_q;
  logic [TempW-1:0] d_t_q;
  logic [UpW-1:0]   d_up_q;
  logic             d_fault_q, d_v_q;
  logic [DW-1:0]    t_full, b6;
  logic [TempW-1:0] t_sat;
  assign t_full = $signed(c_b5_q + 32'd8) >>> 4;
  assign b6     = c_b5_q - TempBias;

  always_comb begin
    if ($signed(t_full) < TempMin) begin
      t_sat = TempMin[TempW-1:0];
    end else if ($signed(t_full) > TempMax) begin
      t_sat = TempMax[TempW-1:0];
    end else begin
      t_sat = t_full[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_b6_q    <= b6;
      d_sq_q    <= b6 * b6;
      d_t_q     <= t_sat;
      d_up_q    <= c_up_q;
      d_fault_q <= c_fault_q;
    end
  end

  // Stage E: four coefficient products
  logic [DW-1:0]    e_p1_q, e_p2_q, e_p3_q, e_p4_q;
  logic [TempW-1:0] e_t_q;
  logic [UpW-1:0]   e_up_q;
  logic             e_fault_q, e_v_q;
  logic [DW-1:0]    sq;
  assign sq = $signed(d_sq_q) >>> 12;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_p1_q    <= b2 * sq;
      e_p2_q    <= ac2 * d_b6_q;
      e_p3_q    <= ac3 * d_b6_q;
      e_p4_q    <= b1 * sq;
      e_t_q     <= d_t_q;
      e_up_q    <= d_up_q;
      e_fault_q <= d_fault_q;
    end
  end

  // Stage F: B3 and the B4 operand
  logic [DW-1:0]    f_b3_q, f_x3_q;
  logic [TempW-1:0] f_t_q;
  logic [UpW-1:0]   f_up_q;
  logic             f_fault_q, f_v_q;
  logic [DW-1:0]    x3a, x3b, sumb;
  assign x3a  = ($signed(e_p1_q) >>> 11) + ($signed(e_p2_q) >>> 11);
  assign sumb = $unsigned($signed(e_p3_q) >>> 13) + $unsigned($signed(e_p4_q) >>> 16) + 32'd2;
  assign x3b  = $signed(sumb) >>> 2;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_b3_q    <= $signed((((ac1 << 2) + x3a) << oss_q) + 32'd2) >>> 2;
      f_x3_q    <= x3b + B4Bias;
      f_t_q     <= e_t_q;
      f_up_q    <= e_up_q;
      f_fault_q <= e_fault_q;
    end
  end

  // Stage G: B4 and UP - B3
  logic [DW-1:0]    g_b4_q, g_diff_q;
  logic [TempW-1:0] g_t_q;
  logic             g_fault_q, g_v_q;
  logic [DW-1:0]    b4_prod;
  assign b4_prod = ac4 * f_x3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_b4_q    <= b4_prod >> 15;
      g_diff_q  <= {8'd0, f_up_q} - f_b3_q;
      g_t_q     <= f_t_q;
      g_fault_q <= f_fault_q;
    end
  end

  // Stage H: B7
  logic [DW-1:0]    h_b7_q, h_b4_q;
  logic [TempW-1:0] h_t_q;
  logic             h_fault_q, h_v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_b7_q    <= g_diff_q * (PresScale >> oss_q);
      h_b4_q    <= g_b4_q;
      h_t_q     <= g_t_q;
      h_fault_q <= g_fault_q || (g_b4_q == '0);
    end
  end

  // Two-branch unsigned pressure divide
  localparam int unsigned Side2W = TempW + 2;
  logic [DW-1:0]     num2, quo2;
  logic [Side2W-1:0] side2_out;
  logic              d2_v;
  assign num2 = h_b7_q[DW-1] ? h_b7_q : (h_b7_q << 1);

  bpc_div #(.SideW(Side2W)) u_div_pres (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (h_v_q),
    .num_i   (num2),
    .den_i   (h_b4_q),
    .side_i  ({h_b7_q[DW-1], h_fault_q, h_t_q}),
    .valid_o (d2_v),
    .quo_o   (quo2),
    .side_o  (side2_out)
  );

  // Stage I: raw pressure
  logic [DW-1:0]    i_p_q;
  logic [TempW-1:0] i_t_q;
  logic             i_fault_q, i_v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      i_p_q     <= side2_out[Side2W-1] ? (quo2 << 1) : quo2;
      i_t_q     <= side2_out[TempW-1:0];
      i_fault_q <= side2_out[TempW];
    end
  end

  // Stage J: polynomial products
  logic [DW-1:0]    j_sq_q, j_m_q, j_p_q;
  logic [TempW-1:0] j_t_q;
  logic             j_fault_q, j_v_q;
  logic [DW-1:0]    p8;
  assign p8 = $signed(i_p_q) >>> 8;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j_sq_q    <= p8 * p8;
      j_m_q     <= PolyB * i_p_q;
      j_p_q     <= i_p_q;
      j_t_q     <= i_t_q;
      j_fault_q <= i_fault_q;
    end
  end

  // Stage K: scale the square term
  logic [DW-1:0]    k_x1_q, k_m_q, k_p_q;
  logic [TempW-1:0] k_t_q;
  logic             k_fault_q, k_v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k_x1_q    <= j_sq_q * PolyA;
      k_m_q     <= j_m_q;
      k_p_q     <= j_p_q;
      k_t_q     <= j_t_q;
      k_fault_q <= j_fault_q;
    end
  end

  // Stage L (output register): correction, saturation, fault override
  logic [DW-1:0]    px1, px2, pcor, pfin;
  logic [PresW-1:0] p_sat;
  logic [TempW-1:0] out_t_q;
  logic [PresW-1:0] out_p_q;
  logic             out_f_q;
  assign px1  = $signed(k_x1_q) >>> 16;
  assign px2  = $signed(32'd0 - k_m_q) >>> 16;
  assign pcor = px1 + px2 + PolyC;
  assign pfin = k_p_q + $unsigned($signed(pcor) >>> 4);

  always_comb begin
    if (pfin[DW-1]) begin
      p_sat = '0;
    end else if ($signed(pfin) > PresMax) begin
      p_sat = PresMax[PresW-1:0];
    end else begin
      p_sat = pfin[PresW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_t_q <= k_fault_q ? '0 : k_t_q;
      out_p_q <= k_fault_q ? '0 : p_sat;
      out_f_q <= k_fault_q;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      h_v_q   <= 1'b0;
      i_v_q   <= 1'b0;
      j_v_q   <= 1'b0;
      k_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q   <= in_fire;
      b_v_q   <= a_v_q;
      c_v_q   <= d1_v;
      d_v_q   <= c_v_q;
      e_v_q   <= d_v_q;
      f_v_q   <= e_v_q;
      g_v_q   <= f_v_q;
      h_v_q   <= g_v_q;
      i_v_q   <= d2_v;
      j_v_q   <= i_v_q;
      k_v_q   <= j_v_q;
      out_v_q <= k_v_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, out_p_q, out_t_q};
  assign m_axis_tuser  = out_f_q;

  // A faulted beat carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("faulted beat with nonzero data");

  // A stalled output beat blocks intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("intake open while output stalled");

  // While stalled the pipeline holds its occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(k_v_q) && $stable(h_v_q) && $stable(a_v_q)))
    else $error("pipeline moved during stall");

endmodule

// ===== bench/barometer_temp_pressure_compensation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_checker
// Watches both streams and the calibration port, predicts each compensated
// result from the accepted sample beat and compares it with the output beat.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_checker import bpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [31:0]        m_axis_tdata,
  input  logic               m_axis_tuser,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DW-1:0]      cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [PresW-1:0] pres;
    logic             fault;
  } comp_t;

  logic [31:0] pair_a, pair_b, pair_c, pair_d, pair_e;
  logic [1:0]  oss;
  comp_t       comp_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = comp_q.size();

  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] sra(input logic [31:0] x, input int s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sdiv32(input logic [31:0] n, input logic [31:0] d);
    longint q;
    q = longint'($signed(n)) / longint'($signed(d));
    return q[31:0];
  endfunction

  function automatic comp_t compensate(input logic [15:0] ut, input logic [23:0] raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, up;
    logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, sq, p, dv;
    longint      t, pv;
    comp_t       r;
    ac1 = sx16(pair_a[31:16]); ac2 = sx16(pair_a[15:0]);
    ac3 = sx16(pair_b[31:16]); ac4 = {16'd0, pair_b[15:0]};
    ac5 = {16'd0, pair_c[31:16]}; ac6 = {16'd0, pair_c[15:0]};
    b1 = sx16(pair_d[31:16]); b2 = sx16(pair_d[15:0]);
    mc = sx16(pair_e[31:16]); md = sx16(pair_e[15:0]);
    up = {8'd0, raw} >> (8 - oss);
    r = '0;
    x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = sdiv32(mc << 11, dv);
    b5 = x1 + x2;
    t  = longint'($signed(sra(b5 + 32'd8, 4)));
    b6 = b5 - TempBias;
    sq = sra(b6 * b6, 12);
    x3 = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
    b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + B4Bias)) >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = (up - b3) * (PresScale >> oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else         p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * PolyA, 16);
    x2 = sra(32'd0 - PolyB * p, 16);
    p  = p + sra(x1 + x2 + PolyC, 4);
    pv = longint'($signed(p));
    if (t < -2048) t = -2048;
    if (t > 2047) t = 2047;
    if (pv < 0) pv = 0;
    if (pv > 131071) pv = 131071;
    r.temp = t[TempW-1:0];
    r.pres = pv[PresW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    comp_t want;
    if (!rst_ni) begin
      pair_a <= '0; pair_b <= '0; pair_c <= '0; pair_d <= '0; pair_e <= '0;
      oss    <= '0;
      fails  = 0;
      comp_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAIR_A:   pair_a <= cfg_data_i;
          CFG_PAIR_B:   pair_b <= cfg_data_i;
          CFG_PAIR_C:   pair_c <= cfg_data_i;
          CFG_PAIR_D:   pair_d <= cfg_data_i;
          CFG_PAIR_E:   pair_e <= cfg_data_i;
          CFG_OVERSAMP: oss    <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        comp_q.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[39:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (comp_q.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          fails++;
        end else begin
          want = comp_q.pop_front();
          if (m_axis_tdata[11:0] !== want.temp)
            report_mismatch("temperature", $signed(m_axis_tdata[11:0]), $signed(want.temp));
          if (m_axis_tdata[28:12] !== want.pres)
            report_mismatch("pressure", m_axis_tdata[28:12], want.pres);
          if (m_axis_tuser !== want.fault)
            report_mismatch("divide_fault", m_axis_tuser, want.fault);
        end
      end
    end
  end

endmodule

// ===== bench/barometer_temp_pressure_compensation_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// barometer_temp_pressure_compensation_test
// Drives sample beats through several calibration sets and lets the checker
// compare every compensated result; random idling on both stream sides.
// ----------------------------------------------------------------------------
module barometer_temp_pressure_compensation_test;
  import bpc_pkg::*;

  localparam int Latency   = 76;
  localparam int WatchLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DW-1:0]      cfg_data_i = '0;
  int                 fail_count, pending;
  int                 idle_cycles = 0;
  int                 sink_wait = 0;
  bit                 hold_sink = 1'b0;   // long receiver hold-off

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  barometer_temp_pressure_compensation u_top (.*);

  barometer_temp_pressure_compensation_checker u_check (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Write one calibration register; the block must be idle.
  task automatic write_cal(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait until every result is back, then let the pipe drain.
  task automatic drain_pipe();
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Offer one sample beat, after a random gap when gaps is set; hold until accepted.
  task automatic send_sample(input logic [15:0] ut, input logic [23:0] raw, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {raw, ut};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // Load a typical sensor calibration with random spread.
  task automatic load_typical(input logic [1:0] os);
    write_cal(CFG_PAIR_A, {16'(408 + $urandom_range(0, 64)), 16'(-72 - $urandom_range(0, 30))});
    write_cal(CFG_PAIR_B, {16'(-14383 + $urandom_range(0, 200)), 16'(32741 + $urandom_range(0, 500))});
    write_cal(CFG_PAIR_C, {16'(32757 + $urandom_range(0, 200)), 16'(23153 + $urandom_range(0, 300))});
    write_cal(CFG_PAIR_D, {16'(6190), 16'(4 + $urandom_range(0, 8))});
    write_cal(CFG_PAIR_E, {16'(-8711 + $urandom_range(0, 100)), 16'(2868 - $urandom_range(0, 100))});
    write_cal(CFG_OVERSAMP, {30'd0, os});
  endtask

  // Receiver: draw a wait for every beat, mostly zero.
  always @(posedge clk_i) begin
    int wait_n;
    wait_n = sink_wait;
    if (m_axis_tvalid && m_axis_tready)
      wait_n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
    else if (wait_n > 0)
      wait_n = wait_n - 1;
    sink_wait     <= wait_n;
    m_axis_tready <= !hold_sink && (wait_n == 0);
  end

  // Watchdog: cycles with no beat on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_sink)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero calibration gives a zero temperature divisor.
    send_sample(16'h0000, 24'h000000, 1'b0);
    send_sample(16'hFFFF, 24'hFFFFFF, 1'b0);
    end_burst();
    drain_pipe();

    // Zero pressure divisor: AC4 zero; then a temperature divide of -2^26 by -1.
    write_cal(CFG_PAIR_E, {16'h0001, 16'h0001});
    send_sample(16'h1234, 24'h800000, 1'b0);
    end_burst();
    drain_pipe();
    write_cal(CFG_PAIR_C, 32'h0000_0000);
    write_cal(CFG_PAIR_E, {16'h8000, 16'hFFFF});
    write_cal(CFG_PAIR_B, {16'h7FFF, 16'hFFFF});
    send_sample(16'h0000, 24'hFFFFFF, 1'b0);
    end_burst();
    drain_pipe();

    // Extreme calibration words, each oversampling setting.
    for (int os = 0; os < 4; os++) begin
      write_cal(CFG_PAIR_A, os[0] ? 32'hFFFF_FFFF : 32'h8000_7FFF);
      write_cal(CFG_PAIR_B, os[1] ? 32'h7FFF_FFFF : 32'h8000_0001);
      write_cal(CFG_PAIR_C, 32'hFFFF_FFFF);
      write_cal(CFG_PAIR_D, os[0] ? 32'h7FFF_8000 : 32'h8000_7FFF);
      write_cal(CFG_PAIR_E, os[1] ? 32'h7FFF_8001 : 32'h8000_7FFF);
      write_cal(CFG_OVERSAMP, 32'(os));
      send_sample(16'h0000, 24'h000000, 1'b0);
      send_sample(16'hFFFF, 24'hFFFFFF, 1'b0);
      send_sample(16'h8000, 24'h5A5A5A, 1'b0);
      end_burst();
      drain_pipe();
    end

    // Random phases: mostly realistic calibration, some fully random words.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2) begin
        write_cal(CFG_PAIR_A, $urandom());
        write_cal(CFG_PAIR_B, $urandom());
        write_cal(CFG_PAIR_C, $urandom());
        write_cal(CFG_PAIR_D, $urandom());
        write_cal(CFG_PAIR_E, $urandom());
        write_cal(CFG_OVERSAMP, $urandom());
      end else begin
        load_typical(2'(ph));
      end
      if (ph == 4) fork
        begin
          hold_sink = 1'b1;
          repeat (300) @(posedge clk_i);
          hold_sink = 1'b0;
        end
      join_none
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_sample(16'($urandom()), 24'($urandom()), bit'(ph % 2));
        else
          send_sample(16'($urandom_range(20000, 32000)),
                      24'($urandom_range(0, 24'hFFFFFF)), bit'(ph % 2));
      end
      end_burst();
      drain_pipe();   // sender pauses until all results are back
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
